[rtl/core/rhs_pkg.sv]
package rhs_pkg;

  // Store geometry.
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  // Operation codes.
  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_LOAD_CUR  = 3'd1;
  localparam logic [2:0] OP_LOAD_CAND = 3'd2;
  localparam logic [2:0] OP_EVALUATE  = 3'd3;
  localparam logic [2:0] OP_READ_SEL  = 3'd4;
  localparam logic [2:0] OP_READ_ADD  = 3'd5;
  localparam logic [2:0] OP_READ_REM  = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ID   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Merge modes; codes with the upper bit set toggle.
  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_UNION   = 2'd1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_MX0  = 3'd1;
  localparam logic [2:0] REG_MY0  = 3'd2;
  localparam logic [2:0] REG_MX1  = 3'd3;
  localparam logic [2:0] REG_MY1  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        stable_id;
    logic signed [31:0] box_x0;
    logic signed [31:0] box_y0;
    logic signed [31:0] box_x1;
    logic signed [31:0] box_y1;
    logic [7:0]         read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  set_count;
    logic [63:0] entry_id;
  } rsp_t;

  // A normalised rectangle: corner 0 is the smaller corner.
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } box_t;

  // Inclusive overlap of a stored rectangle with the normalised marquee.
  function automatic logic box_hit(input box_t b, input box_t m);
    box_hit = (m.x0 <= b.x1) && (m.x1 >= b.x0) && (m.y0 <= b.y1) && (m.y1 >= b.y0);
  endfunction

endpackage

[rtl/core/rhs_ram.sv]
module rhs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rect_hit_selection_set_merge.sv]
// Marquee hit selection with sorted set merge. Ids are loaded into a current
// list and a candidate list (with rectangles), evaluate keeps the candidates
// that overlap the marquee and merges them with the current ids by the mode
// register, and the selection, added and removed sets are then read back by
// index in ascending order. Evaluate sorts both lists by ranking: each stored
// id is compared with every id of its list, one RAM read per cycle, and then
// the merge steps over the sorted current ids and hits. No clearing pass is
// needed after reset.
module rect_hit_selection_set_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rhs_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rhs_pkg::rsp_t       rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rhs_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_RDWAIT  = 4'd2;
  localparam logic [3:0] S_FIN     = 4'd3;
  localparam logic [3:0] S_RK_NEXT = 4'd4;
  localparam logic [3:0] S_RK_I    = 4'd5;
  localparam logic [3:0] S_RK_HOLD = 4'd6;
  localparam logic [3:0] S_RK_SCAN = 4'd7;
  localparam logic [3:0] S_RK_WR   = 4'd8;
  localparam logic [3:0] S_MG_RD   = 4'd9;
  localparam logic [3:0] S_MG_CMP  = 4'd10;
  localparam logic [3:0] S_MG_END  = 4'd11;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Configuration registers.
  logic [1:0]         mode;
  logic signed [31:0] mx0, my0, mx1, my1;
  box_t               marquee;

  logic [3:0]       state;
  req_t             req_q;
  rsp_t             res;
  logic [CNT_W-1:0] cur_n, cand_n;
  logic [1:0]       load_err;
  logic [CNT_W-1:0] cnt_sel, cnt_add, cnt_rem;

  // Ranking sequencer.
  logic             phase;
  logic [CNT_W-1:0] i, j, pj, rank, hit_n, list_n;
  logic             pv, bad, key_hit;
  logic [63:0]      key;
  logic [IDX_W-1:0] scan_addr;
  logic [63:0]      scan_id;

  // Merge sequencer.
  logic [CNT_W-1:0] mi, mj, sel_n, add_n, rem_n;
  logic             ovf;
  logic             ai, bj, only_l, only_r, both;
  logic             push_sel, push_add, push_rem, sel_full;
  logic             is_replace, is_toggle;

  // RAM ports.
  logic [63:0] cur_rd, cand_id_rd, scur_rd, hit_rd, sel_rd, add_rd, rem_rd;
  logic [127:0] box_rd;
  box_t        box_in, box_scan;
  logic        we_cur, we_cand, we_scur, we_hit, we_sel, we_add, we_rem;
  logic        out_free;
  logic [CNT_W-1:0] rd_count;
  logic [63:0]      rd_entry;

  // Configuration port: writes in the access phase, reads return the value.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_REPLACE;
      mx0  <= '0;
      my0  <= '0;
      mx1  <= '0;
      my1  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_MODE: mode <= pwdata[1:0];
        REG_MX0:  mx0  <= pwdata;
        REG_MY0:  my0  <= pwdata;
        REG_MX1:  mx1  <= pwdata;
        REG_MY1:  my1  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE: prdata = {30'd0, mode};
      REG_MX0:  prdata = mx0;
      REG_MY0:  prdata = my0;
      REG_MX1:  prdata = mx1;
      REG_MY1:  prdata = my1;
      default:  prdata = '0;
    endcase
  end

  // Normalised marquee.
  always_comb begin
    marquee.x0 = (mx0 > mx1) ? mx1 : mx0;
    marquee.x1 = (mx0 > mx1) ? mx0 : mx1;
    marquee.y0 = (my0 > my1) ? my1 : my0;
    marquee.y1 = (my0 > my1) ? my0 : my1;
  end

  // Normalised rectangle of the candidate being loaded.
  always_comb begin
    box_in.x0 = (req_q.box_x0 > req_q.box_x1) ? req_q.box_x1 : req_q.box_x0;
    box_in.x1 = (req_q.box_x0 > req_q.box_x1) ? req_q.box_x0 : req_q.box_x1;
    box_in.y0 = (req_q.box_y0 > req_q.box_y1) ? req_q.box_y1 : req_q.box_y0;
    box_in.y1 = (req_q.box_y0 > req_q.box_y1) ? req_q.box_y0 : req_q.box_y1;
  end

  assign box_scan  = box_t'(box_rd);
  assign scan_id   = phase ? cand_id_rd : cur_rd;
  assign list_n    = phase ? cand_n : cur_n;
  assign scan_addr = (state == S_RK_SCAN) ? j[IDX_W-1:0] : i[IDX_W-1:0];

  // Merge step classification.
  assign is_replace = (mode == MODE_REPLACE);
  assign is_toggle  = mode[1];
  assign ai       = (mi < cur_n);
  assign bj       = (mj < hit_n);
  assign only_l   = ai && (!bj || (scur_rd < hit_rd));
  assign only_r   = bj && (!ai || (hit_rd < scur_rd));
  assign both     = ai && bj && !only_l && !only_r;
  assign push_sel = only_r || (only_l && !is_replace) || (both && !is_toggle);
  assign push_add = only_r;
  assign push_rem = (only_l && is_replace) || (both && is_toggle);
  assign sel_full = (sel_n == CAP_CNT);

  // Write enables.
  assign we_cur  = (state == S_EXEC) && (req_q.op == OP_LOAD_CUR) && (cur_n < CAP_CNT);
  assign we_cand = (state == S_EXEC) && (req_q.op == OP_LOAD_CAND) && (cand_n < CAP_CNT);
  assign we_scur = (state == S_RK_WR) && !phase;
  assign we_hit  = (state == S_RK_WR) && phase && key_hit;
  assign we_sel  = (state == S_MG_CMP) && (ai || bj) && push_sel && !sel_full;
  assign we_add  = (state == S_MG_CMP) && (ai || bj) && push_add && !(push_sel && sel_full);
  assign we_rem  = (state == S_MG_CMP) && (ai || bj) && push_rem && !(push_sel && sel_full);

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_cur_ram (
    .clk, .we(we_cur), .waddr(cur_n[IDX_W-1:0]), .wdata(req_q.stable_id),
    .raddr(scan_addr), .rdata(cur_rd));

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_cand_id_ram (
    .clk, .we(we_cand), .waddr(cand_n[IDX_W-1:0]), .wdata(req_q.stable_id),
    .raddr(scan_addr), .rdata(cand_id_rd));

  rhs_ram #(.WIDTH(128), .DEPTH(CAPACITY)) u_cand_box_ram (
    .clk, .we(we_cand), .waddr(cand_n[IDX_W-1:0]), .wdata(box_in),
    .raddr(scan_addr), .rdata(box_rd));

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_scur_ram (
    .clk, .we(we_scur), .waddr(rank[IDX_W-1:0]), .wdata(key),
    .raddr(mi[IDX_W-1:0]), .rdata(scur_rd));

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_hit_ram (
    .clk, .we(we_hit), .waddr(rank[IDX_W-1:0]), .wdata(key),
    .raddr(mj[IDX_W-1:0]), .rdata(hit_rd));

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_sel_ram (
    .clk, .we(we_sel), .waddr(sel_n[IDX_W-1:0]), .wdata(only_l ? scur_rd : hit_rd),
    .raddr(req_q.read_index), .rdata(sel_rd));

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_add_ram (
    .clk, .we(we_add), .waddr(add_n[IDX_W-1:0]), .wdata(hit_rd),
    .raddr(req_q.read_index), .rdata(add_rd));

  rhs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_rem_ram (
    .clk, .we(we_rem), .waddr(rem_n[IDX_W-1:0]), .wdata(scur_rd),
    .raddr(req_q.read_index), .rdata(rem_rd));

  // Read-back selection of the chosen set.
  always_comb begin
    case (req_q.op)
      OP_READ_SEL: begin
        rd_count = cnt_sel;
        rd_entry = sel_rd;
      end
      OP_READ_ADD: begin
        rd_count = cnt_add;
        rd_entry = add_rd;
      end
      default: begin
        rd_count = cnt_rem;
        rd_entry = rem_rd;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // A result stays valid until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_n     <= '0;
      cand_n    <= '0;
      load_err  <= '0;
      cnt_sel   <= '0;
      cnt_add   <= '0;
      cnt_rem   <= '0;
      pv        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (req_q.op)
            OP_CLEAR: begin
              cur_n    <= '0;
              cand_n   <= '0;
              load_err <= '0;
              cnt_sel  <= '0;
              cnt_add  <= '0;
              cnt_rem  <= '0;
              res      <= '0;
              state    <= S_FIN;
            end
            OP_LOAD_CUR: begin
              if (cur_n < CAP_CNT) begin
                cur_n <= cur_n + 1'b1;
                res   <= '{status: load_err, set_count: cur_n + 1'b1, entry_id: 64'd0};
              end else begin
                load_err <= ST_OVERFLOW;
                res      <= '{status: ST_OVERFLOW, set_count: cur_n, entry_id: 64'd0};
              end
              state <= S_FIN;
            end
            OP_LOAD_CAND: begin
              if (cand_n < CAP_CNT) begin
                cand_n <= cand_n + 1'b1;
                res    <= '{status: load_err, set_count: cand_n + 1'b1, entry_id: 64'd0};
              end else begin
                load_err <= ST_OVERFLOW;
                res      <= '{status: ST_OVERFLOW, set_count: cand_n, entry_id: 64'd0};
              end
              state <= S_FIN;
            end
            OP_EVALUATE: begin
              cnt_sel <= '0;
              cnt_add <= '0;
              cnt_rem <= '0;
              if (load_err != ST_OK) begin
                res   <= '{status: ST_OVERFLOW, set_count: 9'd0, entry_id: 64'd0};
                state <= S_FIN;
              end else begin
                phase <= 1'b0;
                i     <= '0;
                bad   <= 1'b0;
                hit_n <= '0;
                state <= S_RK_NEXT;
              end
            end
            OP_READ_SEL, OP_READ_ADD, OP_READ_REM: begin
              state <= S_RDWAIT;
            end
            default: begin
              res   <= '0;
              state <= S_FIN;
            end
          endcase
        end
        S_RDWAIT: begin
          res   <= '{status: ST_OK, set_count: rd_count,
                     entry_id: ({1'b0, req_q.read_index} < rd_count) ? rd_entry : 64'd0};
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        // Walk each list; a finished candidate list ends the ranking.
        S_RK_NEXT: begin
          if (i == list_n) begin
            if (!phase) begin
              phase <= 1'b1;
              i     <= '0;
            end else if (bad) begin
              res   <= '{status: ST_BAD_ID, set_count: 9'd0, entry_id: 64'd0};
              state <= S_FIN;
            end else begin
              mi    <= '0;
              mj    <= '0;
              sel_n <= '0;
              add_n <= '0;
              rem_n <= '0;
              ovf   <= 1'b0;
              state <= S_MG_RD;
            end
          end else begin
            state <= S_RK_I;
          end
        end
        S_RK_I: begin
          state <= S_RK_HOLD;
        end
        S_RK_HOLD: begin
          key     <= scan_id;
          key_hit <= box_hit(box_scan, marquee);
          j       <= '0;
          pv      <= 1'b0;
          rank    <= '0;
          state   <= S_RK_SCAN;
        end
        // Compare the held id with every id of its list, one read per cycle.
        S_RK_SCAN: begin
          if (j < list_n) begin
            j  <= j + 1'b1;
            pj <= j;
            pv <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if ((scan_id == key) && (pj != i)) begin
              bad <= 1'b1;
            end
            if ((scan_id < key) && (!phase || box_hit(box_scan, marquee))) begin
              rank <= rank + 1'b1;
            end
          end else if (j == list_n) begin
            state <= S_RK_WR;
          end
        end
        S_RK_WR: begin
          if (key == 64'd0) begin
            bad <= 1'b1;
          end
          if (phase && key_hit) begin
            hit_n <= hit_n + 1'b1;
          end
          i     <= i + 1'b1;
          state <= S_RK_NEXT;
        end
        S_MG_RD: begin
          state <= S_MG_CMP;
        end
        // One step of the merge of sorted current ids with sorted hits.
        S_MG_CMP: begin
          if (!ai && !bj) begin
            state <= S_MG_END;
          end else if (push_sel && sel_full) begin
            ovf   <= 1'b1;
            state <= S_MG_END;
          end else begin
            if (push_sel) sel_n <= sel_n + 1'b1;
            if (push_add) add_n <= add_n + 1'b1;
            if (push_rem) rem_n <= rem_n + 1'b1;
            if (only_l || both) mi <= mi + 1'b1;
            if (only_r || both) mj <= mj + 1'b1;
            state <= S_MG_RD;
          end
        end
        S_MG_END: begin
          if (ovf) begin
            res <= '{status: ST_OVERFLOW, set_count: 9'd0, entry_id: 64'd0};
          end else begin
            cnt_sel <= sel_n;
            cnt_add <= add_n;
            cnt_rem <= rem_n;
            res     <= '{status: ST_OK, set_count: sel_n, entry_id: 64'd0};
          end
          state <= S_FIN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/rhs_checker.sv]
module rhs_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rhs_pkg::rsp_t rsp,
  input logic          pready
);
  import rhs_pkg::*;

  // A stalled result holds until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Failed operations never carry an id.
  a_err_no_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.entry_id == 64'd0))
    else $error("error result carries an id");

  // Status code three is never produced.
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status != 2'd3))
    else $error("undefined status code");

  // Set sizes never exceed the capacity.
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.set_count <= 9'(CAPACITY)))
    else $error("set size beyond capacity");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("configuration port not ready");

endmodule

bind rect_hit_selection_set_merge rhs_checker u_rhs_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
  .rsp(rsp), .pready(pready));
